@@ rtl/skl_pkg.sv @@
`default_nettype none

package skl_pkg;

    // default number of cells in the chain
    localparam int DEPTH_DEF = 16;

    // key width, fixed by the beat format
    localparam int KEY_W = 32;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_APPLY
    } seq_t;

    // command broadcast to every cell
    typedef struct packed {
        cmd_t cmd;
        logic ins_en;
        logic del_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/skl_cell.sv @@
`default_nettype none

module skl_cell #(
    parameter int DEPTH = skl_pkg::DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire skl_pkg::cell_ctl_t                ctl,
    input  wire logic signed [skl_pkg::KEY_W-1:0]  key,
    input  wire logic [3:0]                        position,
    input  wire logic [CW-1:0]                     held,
    input  wire logic signed [skl_pkg::KEY_W-1:0]  left_entry,
    input  wire logic                              left_ge,
    input  wire logic signed [skl_pkg::KEY_W-1:0]  right_entry,
    input  wire logic                              hit_in,
    input  wire logic [CW-1:0]                     pos_in,
    input  wire logic signed [skl_pkg::KEY_W-1:0]  key_in,
    output logic signed [skl_pkg::KEY_W-1:0]       entry,
    output logic                                   ge,
    output logic                                   hit_out,
    output logic [CW-1:0]                          pos_out,
    output logic signed [skl_pkg::KEY_W-1:0]       key_out
);

    logic signed [skl_pkg::KEY_W-1:0] entry_reg;
    logic signed [skl_pkg::KEY_W-1:0] entry_next;
    logic                             hit_reg;
    logic                             hit_next;
    logic [CW-1:0]                    pos_reg;
    logic [CW-1:0]                    pos_next;
    logic signed [skl_pkg::KEY_W-1:0] key_reg;
    logic signed [skl_pkg::KEY_W-1:0] key_next;
    logic                             valid;
    logic                             lt;
    logic                             match;

    // local compare against the broadcast key
    assign valid = CW'(IDX) < held;
    assign lt    = valid && (entry_reg < key);
    assign ge    = !lt;

    // does this cell answer the current command
    always_comb
    begin
        unique case (ctl.cmd)
            skl_pkg::CMD_INSERT: match = valid && !lt;
            skl_pkg::CMD_DELETE,
            skl_pkg::CMD_SEARCH: match = valid && (entry_reg == key);
            skl_pkg::CMD_READ:   match = valid && (IDX < 16) && (position == 4'(IDX));
            default:             match = 1'b0;
        endcase
    end

    // result carrier: first matching cell claims it, later cells pass it on
    always_comb
    begin
        if (!hit_in && match)
        begin
            hit_next = 1'b1;
            pos_next = CW'(IDX);
            key_next = entry_reg;
        end
        else
        begin
            hit_next = hit_in;
            pos_next = pos_in;
            key_next = key_in;
        end
    end

    // shift on insert or delete, else hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins_en)
        begin
            if (left_ge)
                entry_next = left_entry;
            else if (ge)
                entry_next = key;
        end
        else if (ctl.del_en)
        begin
            if (valid && !lt)
                entry_next = right_entry;
        end
    end

    // stored key
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // carrier stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
    end

    assign entry   = entry_reg;
    assign hit_out = hit_reg;
    assign pos_out = pos_reg;
    assign key_out = key_reg;

endmodule

`default_nettype wire

@@ rtl/sorted_key_list.sv @@
`default_nettype none

// channel   signals                                      handshake
// command   cmd, key, position                           start high, busy low
// result    status, found_position, key_out, count       done high for one cycle
//
// every command runs from start to done through the scan, in which the result
// carrier ripples through the cell chain, the apply step, which applies the
// shift, and the output register
// busy is high from the cycle after a command is taken until done rises
// reset empties the store; key storage itself is not cleared
// results cannot be stalled: done is a single-cycle strobe
module sorted_key_list #(
    parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        cmd,
    input  wire logic signed [skl_pkg::KEY_W-1:0]  key,
    input  wire logic [3:0]                        position,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic [3:0]                             found_position,
    output logic signed [skl_pkg::KEY_W-1:0]       key_out,
    output logic [4:0]                             count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int QW = (CW > 5) ? CW : 5;

    skl_pkg::seq_t                    state_reg;
    skl_pkg::seq_t                    state_next;
    logic [SW-1:0]                    scan_cnt_reg;
    logic [SW-1:0]                    scan_cnt_next;
    skl_pkg::cmd_t                    cmd_reg;
    logic signed [skl_pkg::KEY_W-1:0] key_reg;
    logic [3:0]                       pos_reg;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic                             done_reg;
    skl_pkg::status_t                 status_reg;
    skl_pkg::status_t                 status_next;
    logic [CW-1:0]                    where_reg;
    logic [CW-1:0]                    where_next;
    logic signed [skl_pkg::KEY_W-1:0] kout_reg;
    logic signed [skl_pkg::KEY_W-1:0] kout_next;
    logic                             accept;
    logic                             in_scan;
    logic                             in_apply;
    logic                             scan_last;
    logic                             full;
    skl_pkg::cell_ctl_t               ctl;
    logic [PW-1:0]                    where_ext;
    logic [QW-1:0]                    count_ext;

    logic signed [skl_pkg::KEY_W-1:0] ent      [0:DEPTH-1];
    logic                             ge       [0:DEPTH-1];
    logic signed [skl_pkg::KEY_W-1:0] left_ent [0:DEPTH-1];
    logic                             left_ge  [0:DEPTH-1];
    logic signed [skl_pkg::KEY_W-1:0] right_ent[0:DEPTH-1];
    logic                             car_hit  [0:DEPTH];
    logic [CW-1:0]                    car_pos  [0:DEPTH];
    logic signed [skl_pkg::KEY_W-1:0] car_key  [0:DEPTH];

    assign accept    = start && !busy;
    assign scan_last = scan_cnt_reg == SW'(DEPTH - 1);
    assign full      = count_reg == CW'(DEPTH);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skl_pkg::SQ_IDLE:  if (accept) state_next = skl_pkg::SQ_SCAN;
            skl_pkg::SQ_SCAN:  if (scan_last) state_next = skl_pkg::SQ_APPLY;
            skl_pkg::SQ_APPLY: state_next = skl_pkg::SQ_IDLE;
            default:           state_next = skl_pkg::SQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy     = 1'b1;
        in_scan  = 1'b0;
        in_apply = 1'b0;
        unique case (state_reg)
            skl_pkg::SQ_IDLE:  busy = 1'b0;
            skl_pkg::SQ_SCAN:  in_scan = 1'b1;
            skl_pkg::SQ_APPLY: in_apply = 1'b1;
            default:           busy = 1'b0;
        endcase
    end

    // scan counter
    always_comb
    begin
        if (in_scan)
            scan_cnt_next = scan_cnt_reg + SW'(1);
        else
            scan_cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= skl_pkg::SQ_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    // command beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= skl_pkg::cmd_t'(cmd);
            key_reg <= key;
            pos_reg <= position;
        end
    end

    // result, next fill level and shift enables from the end of the carrier chain
    always_comb
    begin
        status_next = skl_pkg::ST_OK;
        where_next  = '0;
        kout_next   = '0;
        count_next  = count_reg;
        ctl.cmd     = cmd_reg;
        ctl.ins_en  = 1'b0;
        ctl.del_en  = 1'b0;
        unique case (cmd_reg)
            skl_pkg::CMD_INSERT:
            begin
                if (full)
                    status_next = skl_pkg::ST_FULL;
                else
                begin
                    where_next = car_hit[DEPTH] ? car_pos[DEPTH] : count_reg;
                    kout_next  = key_reg;
                    count_next = count_reg + CW'(1);
                    ctl.ins_en = in_apply;
                end
            end
            skl_pkg::CMD_DELETE:
            begin
                if (!car_hit[DEPTH])
                    status_next = skl_pkg::ST_NOT_FOUND;
                else
                begin
                    where_next = car_pos[DEPTH];
                    kout_next  = car_key[DEPTH];
                    count_next = count_reg - CW'(1);
                    ctl.del_en = in_apply;
                end
            end
            skl_pkg::CMD_SEARCH:
            begin
                if (!car_hit[DEPTH])
                    status_next = skl_pkg::ST_NOT_FOUND;
                else
                begin
                    where_next = car_pos[DEPTH];
                    kout_next  = car_key[DEPTH];
                end
            end
            skl_pkg::CMD_READ:
            begin
                if (!car_hit[DEPTH])
                    status_next = skl_pkg::ST_RANGE;
                else
                begin
                    where_next = car_pos[DEPTH];
                    kout_next  = car_key[DEPTH];
                end
            end
            default:
            begin
                status_next = skl_pkg::ST_RANGE;
            end
        endcase
    end

    // fill level and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= in_apply;
            if (in_apply)
                count_reg <= count_next;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (in_apply)
        begin
            status_reg <= status_next;
            where_reg  <= where_next;
            kout_reg   <= kout_next;
        end
    end

    // chain ends
    assign car_hit[0] = 1'b0;
    assign car_pos[0] = '0;
    assign car_key[0] = '0;

    // cell chain with neighbour links
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_ent[i] = key_reg;
            assign left_ge[i]  = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_ent[i] = ent[i-1];
            assign left_ge[i]  = ge[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_ent[i] = key_reg;
        end
        else
        begin : g_inner_right
            assign right_ent[i] = ent[i+1];
        end

        skl_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (key_reg),
            .position    (pos_reg),
            .held        (count_reg),
            .left_entry  (left_ent[i]),
            .left_ge     (left_ge[i]),
            .right_entry (right_ent[i]),
            .hit_in      (car_hit[i]),
            .pos_in      (car_pos[i]),
            .key_in      (car_key[i]),
            .entry       (ent[i]),
            .ge          (ge[i]),
            .hit_out     (car_hit[i+1]),
            .pos_out     (car_pos[i+1]),
            .key_out     (car_key[i+1])
        );
    end

    // output ports, low bits of position and fill level
    assign where_ext      = PW'(where_reg);
    assign count_ext      = QW'(count_reg);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = where_ext[3:0];
    assign key_out        = kout_reg;
    assign count          = count_ext[4:0];

`ifndef ASSERT_OFF
    // a taken command is answered after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(DEPTH + 2) done_reg)
        else $error("result strobe missing after command");

    // done follows an apply cycle only
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == skl_pkg::SQ_APPLY))
        else $error("result strobe without apply");

    // fill level stays within the chain
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill level beyond depth");

    // fill level moves only on apply
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_apply |=> $stable(count_reg))
        else $error("fill level changed outside apply");
`endif

endmodule

`default_nettype wire
